// ----- hw/rtl/bloom_filter_two_hash_defines.svh -----
// Assertion macros used by the controller RTL.
`ifndef BLOOM_FILTER_TWO_HASH_DEFINES_SVH
`define BLOOM_FILTER_TWO_HASH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFTH_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFTH_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bfth_pkg.sv -----
package bfth_pkg;

    // Size of the bit store; any value from 8 to 65536
    localparam int FILTER_BITS = 256;
    localparam int IDX_W       = $clog2(FILTER_BITS);

    // Largest hash value (sdbm over two bytes) stays below 2^25
    localparam int HASH_W  = 25;
    // floor(2^32 / FILTER_BITS) fits 30 bits for FILTER_BITS >= 8
    localparam int RECIP_W = 30;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / FILTER_BITS);
    localparam int PROD_W  = HASH_W + RECIP_W;
    localparam int Q_W     = PROD_W - 32;
    // Remainder before correction is below twice the store size
    localparam int REM_W   = IDX_W + 1;

    // Operation codes
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_TEST  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture operation and hashes
        logic sel_b;     // feed second hash into the reducer
        logic mem_we;    // write the bit store
        logic mem_wd;    // bit value written
        logic clr_addr;  // address the store from the sweep counter
        logic clr_step;  // advance the sweep counter
        logic hit_cap;   // capture first read bit
        logic res_load;  // capture the result bit
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       clr_last;
        logic [1:0] func;
    } dp_status_t;

    // Shift-add-xor hash over low byte then high byte
    function automatic logic [HASH_W-1:0] hash_sax(input logic [7:0] lo, input logic [7:0] hi);
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] mix;
        h1  = HASH_W'(lo);
        mix = (h1 << 5) + (h1 >> 2) + HASH_W'(hi);
        return h1 ^ mix;
    endfunction

    // sdbm hash over low byte then high byte
    function automatic logic [HASH_W-1:0] hash_sdbm(input logic [7:0] lo, input logic [7:0] hi);
        logic [HASH_W-1:0] h1;
        h1 = HASH_W'(lo);
        return HASH_W'(hi) + (h1 << 6) + (h1 << 16) - h1;
    endfunction

endpackage

// ----- hw/rtl/bfth_datapath.sv -----
module bfth_datapath
    import bfth_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [1:0]       func,
    input  logic [15:0]      key,
    output dp_status_t       status,
    output logic             maybe_present
);

    localparam logic [HASH_W-1:0] DIV_C  = HASH_W'(FILTER_BITS);
    localparam logic [REM_W-1:0]  DIV_R  = REM_W'(FILTER_BITS);
    localparam logic [IDX_W-1:0]  LAST_A = IDX_W'(FILTER_BITS - 1);

    logic [1:0]        func_reg;
    logic [HASH_W-1:0] hash_a_reg;
    logic [HASH_W-1:0] hash_b_reg;

    logic [HASH_W-1:0] x_next;
    logic [PROD_W-1:0] prod;
    logic [HASH_W-1:0] x1_reg;
    logic [Q_W-1:0]    q_reg;
    logic [HASH_W-1:0] qd;
    logic [HASH_W-1:0] rem_full;
    logic [REM_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_reg;

    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  clr_cnt_next;
    logic              clr_last;

    logic              mem [FILTER_BITS];
    logic [IDX_W-1:0]  mem_addr;
    logic              rd_data_reg;
    logic              hit_a_reg;
    logic              maybe_reg;
    logic              maybe_next;

    // Item capture: operation and both hash values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            hash_a_reg <= hash_sax(key[7:0], key[15:8]);
            hash_b_reg <= hash_sdbm(key[7:0], key[15:8]);
        end
    end

    // Modulo reducer, three stages: reciprocal multiply, back-multiply, correct
    assign x_next   = cmd.sel_b ? hash_b_reg : hash_a_reg;
    assign prod     = PROD_W'(x_next) * PROD_W'(RECIP);
    assign qd       = HASH_W'(HASH_W'(q_reg) * DIV_C);
    assign rem_full = x1_reg - qd;
    assign idx_next = (rem_reg >= DIV_R) ? IDX_W'(rem_reg - DIV_R) : IDX_W'(rem_reg);

    always_ff @(posedge clk)
    begin
        x1_reg  <= x_next;
        q_reg   <= prod[PROD_W-1:32];
        rem_reg <= REM_W'(rem_full);
        idx_reg <= idx_next;
    end

    // Sweep counter for clearing; wraps to zero at the end of a pass
    assign clr_last     = (clr_cnt_reg == LAST_A);
    assign clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Single-port bit store with registered read
    assign mem_addr = cmd.clr_addr ? clr_cnt_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[mem_addr] <= cmd.mem_wd;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Membership result
    assign maybe_next = (func_reg == FUNC_TEST) & hit_a_reg & rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.hit_cap)
        begin
            hit_a_reg <= rd_data_reg;
        end
        if (cmd.res_load)
        begin
            maybe_reg <= maybe_next;
        end
    end

    assign maybe_present   = maybe_reg;
    assign status.clr_last = clr_last;
    assign status.func     = func_reg;

endmodule

// ----- hw/rtl/bfth_ctrl.sv -----
`include "bloom_filter_two_hash_defines.svh"

module bfth_ctrl
    import bfth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RED_A = 4'd2;
    localparam logic [3:0] ST_RED_B = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_ACC_A = 4'd5;
    localparam logic [3:0] ST_ACC_B = 4'd6;
    localparam logic [3:0] ST_CHECK = 4'd7;
    localparam logic [3:0] ST_CLEAR = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;
    logic       is_add;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;
    assign is_add = (status.func == FUNC_ADD);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_addr = 1'b1;
                cmd.clr_step = 1'b1;
                cmd.mem_we   = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A:
            begin
                state_next = (status.func == FUNC_CLEAR) ? ST_CLEAR : ST_RED_B;
            end
            ST_RED_B:
            begin
                cmd.sel_b  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_ACC_A;
            end
            ST_ACC_A:
            begin
                cmd.mem_we = is_add;
                cmd.mem_wd = 1'b1;
                state_next = ST_ACC_B;
            end
            ST_ACC_B:
            begin
                cmd.mem_we  = is_add;
                cmd.mem_wd  = 1'b1;
                cmd.hit_cap = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.res_load = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.clr_addr = 1'b1;
                cmd.clr_step = 1'b1;
                cmd.mem_we   = 1'b1;
                if (status.clr_last)
                begin
                    cmd.res_load = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    `BFTH_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted item did not raise busy")
    `BFTH_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "result strobe held two cycles")
    `BFTH_ASSERT_IMPL(a_set_only_add, clk, rst_n, cmd.mem_we && !cmd.clr_addr, (state_reg == ST_ACC_A || state_reg == ST_ACC_B) && is_add, "store bit set outside an add")
    `BFTH_ASSERT_IMPL(a_init_quiet, clk, rst_n, state_reg == ST_INIT, !done_reg, "result during reset clearing pass")

endmodule

// ----- hw/rtl/bloom_filter_two_hash.sv -----
// Two-hash Bloom filter over a single-port bit store of FILTER_BITS bits.
// Command channel: func and key are taken at a rising edge where start is
// high and busy is low. func: add key, test key, or clear the whole store.
// Result channel: done pulses for one cycle with maybe_present, which is 1
// only for a test whose two hashed bits are both set. The receiver cannot
// stall; every transfer in gives exactly one result.
// Add/test: busy stays high until the result; it drops in the same cycle
// that done pulses, so a new item is taken only after the last result. The
// work is the three-stage modulo reducer (shared by both hashes) followed by
// two accesses on the single store port and one registered read.
// Clear: one store bit per cycle across the whole store, then the result.
// Reset: asynchronous, active low. After reset a clearing pass over every
// store bit runs with busy high before the first transfer.
module bloom_filter_two_hash
    import bfth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [15:0] key,
    output logic        done,
    output logic        maybe_present
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    bfth_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // Hashing, reduction and bit store
    bfth_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .key           (key),
        .status        (status),
        .maybe_present (maybe_present)
    );

endmodule

// ----- bench/tb_bloom_filter_two_hash.sv -----
module tb_bloom_filter_two_hash;
    import bfth_pkg::*;

    // Operation code with no defined action
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 450;
    // Longest correct stretch with no transfer is a clear sweep or the reset pass
    localparam int IDLE_LIMIT = 4 * (FILTER_BITS + 64);

    typedef struct {
        logic [1:0]  op;
        logic [15:0] k;
        bit          drain;   // hold off until every result is back
    } bloom_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  func = FUNC_ADD;
    logic [15:0] key = 16'h0000;
    logic        busy;
    logic        done;
    logic        maybe_present;

    bloom_cmd_t       pending_cmds[$];
    logic             expected_present[$];
    logic [FILTER_BITS-1:0] shadow_bits = '0;

    int n_accepted = 0;
    int n_results = 0;
    int err_cnt = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;

    bloom_filter_two_hash dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .key           (key),
        .done          (done),
        .maybe_present (maybe_present)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Shift-add-xor hash, low byte then high byte, reduced to a bit index
    function automatic logic [IDX_W-1:0] sax_index(input logic [15:0] cmd_key);
        logic [31:0] h;
        h = 32'(cmd_key[7:0]);
        h = h ^ ((h << 5) + (h >> 2) + 32'(cmd_key[15:8]));
        return IDX_W'(h % 32'(FILTER_BITS));
    endfunction

    // sdbm hash, low byte then high byte, reduced to a bit index
    function automatic logic [IDX_W-1:0] sdbm_index(input logic [15:0] cmd_key);
        logic [31:0] h;
        h = 32'(cmd_key[7:0]);
        h = 32'(cmd_key[15:8]) + (h << 6) + (h << 16) - h;
        return IDX_W'(h % 32'(FILTER_BITS));
    endfunction

    // Update the shadow store and queue the expected answer
    task automatic predict_membership(input logic [1:0] op, input logic [15:0] cmd_key);
        logic [IDX_W-1:0] ia;
        logic [IDX_W-1:0] ib;
        logic             hit;
        ia = sax_index(cmd_key);
        ib = sdbm_index(cmd_key);
        hit = 1'b0;
        case (op)
            FUNC_ADD: begin
                shadow_bits[ia] = 1'b1;
                shadow_bits[ib] = 1'b1;
            end
            FUNC_TEST: hit = shadow_bits[ia] & shadow_bits[ib];
            FUNC_CLEAR: shadow_bits = '0;
            default: ;
        endcase
        expected_present.push_back(hit);
    endtask

    // Driver: bursts of commands with random gaps, start held until taken
    always @(posedge clk) begin
        bit took;
        bit drive_now;
        took = 1'b0;
        drive_now = 1'b0;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            took = start && !busy;
            if (took) begin
                predict_membership(func, key);
                void'(pending_cmds.pop_front());
                n_accepted++;
            end
            if (start && !took) begin
                drive_now = 1'b1;
            end
            else if (gap_left > 0) begin
                gap_left--;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && n_results != n_accepted)) begin
                drive_now = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else begin
                    burst_left--;
                end
            end
            start <= drive_now;
            if (drive_now) begin
                func <= pending_cmds[0].op;
                key <= pending_cmds[0].k;
            end
        end
    end

    // Monitor: every done strobe is one result transfer
    always @(posedge clk) begin
        logic want;
        if (rst_n && done) begin
            if (expected_present.size() == 0) begin
                if (err_cnt < 10)
                    $display("unexpected result: maybe_present=%b", maybe_present);
                err_cnt++;
            end
            else begin
                want = expected_present.pop_front();
                if (maybe_present !== want) begin
                    if (err_cnt < 10)
                        $display("result %0d: maybe_present expected %b got %b",
                                 n_results, want, maybe_present);
                    err_cnt++;
                end
            end
            n_results <= n_results + 1;
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_bloom_filter_two_hash: errors");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [15:0] collide_key;
        logic [15:0] key_pool[24];
        logic [1:0]  op;
        logic [15:0] k;
        int          r;

        // A key whose two hashes land on the same bit
        collide_key = 16'h0000;
        for (int c = 1; c < 65536; c++) begin
            if (sax_index(16'(c)) == sdbm_index(16'(c))) begin
                collide_key = 16'(c);
                break;
            end
        end

        // Directed: extremes, every operation, unused code, shared bit
        pending_cmds.push_back('{FUNC_TEST,   16'h0000, 1'b0});
        pending_cmds.push_back('{FUNC_ADD,    16'h0000, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'h0000, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'hFFFF, 1'b0});
        pending_cmds.push_back('{FUNC_ADD,    16'hFFFF, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'hFFFF, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'h00FF, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'hFF00, 1'b0});
        pending_cmds.push_back('{FUNC_UNUSED, 16'hFFFF, 1'b0});
        pending_cmds.push_back('{FUNC_UNUSED, 16'h1234, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'h1234, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   collide_key, 1'b0});
        pending_cmds.push_back('{FUNC_ADD,    collide_key, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   collide_key, 1'b0});
        pending_cmds.push_back('{FUNC_ADD,    16'h8001, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'h0180, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'h8001, 1'b1});
        pending_cmds.push_back('{FUNC_CLEAR,  16'hFFFF, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'hFFFF, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   collide_key, 1'b0});
        pending_cmds.push_back('{FUNC_ADD,    16'h5AA5, 1'b0});
        pending_cmds.push_back('{FUNC_CLEAR,  16'h0000, 1'b0});
        pending_cmds.push_back('{FUNC_TEST,   16'h5AA5, 1'b1});

        // Random: adds and tests over a small key pool so tests hit,
        // with stray keys, extremes, clears and the unused code mixed in
        foreach (key_pool[i])
            key_pool[i] = 16'($urandom);
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38)
                op = FUNC_ADD;
            else if (r < 90)
                op = FUNC_TEST;
            else if (r < 95)
                op = FUNC_CLEAR;
            else
                op = FUNC_UNUSED;
            r = $urandom_range(0, 9);
            if (r < 6)
                k = key_pool[$urandom_range(0, 23)];
            else if (r < 9)
                k = 16'($urandom);
            else
                case ($urandom_range(0, 3))
                    0: k = 16'h0000;
                    1: k = 16'hFFFF;
                    2: k = 16'h00FF;
                    default: k = 16'hFF00;
                endcase
            if (op == FUNC_CLEAR && $urandom_range(0, 1) == 0)
                key_pool[$urandom_range(0, 23)] = 16'($urandom);
            pending_cmds.push_back('{op, k, ($urandom_range(0, 49) == 0)});
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || n_results != n_accepted)
            @(negedge clk);
        repeat (FILTER_BITS + 16) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_bloom_filter_two_hash: clean");
        else
            $display("tb_bloom_filter_two_hash: errors");
        $finish;
    end

endmodule
